@@ sv/roman_numeral_encoder_defines.svh @@
// shared assertion macros for the roman numeral encoder
`ifndef ROMAN_NUMERAL_ENCODER_DEFINES_SVH
`define ROMAN_NUMERAL_ENCODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RNE_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RNE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rne_pkg.sv @@
package rne_pkg;

    localparam logic [13:0] VALUE_MAX = 14'd9999;
    localparam logic [5:0]  MAX_CHARS = 6'd15;

    localparam logic [6:0] CH_M = 7'h4D;
    localparam logic [6:0] CH_D = 7'h44;
    localparam logic [6:0] CH_C = 7'h43;
    localparam logic [6:0] CH_L = 7'h4C;
    localparam logic [6:0] CH_X = 7'h58;
    localparam logic [6:0] CH_V = 7'h56;
    localparam logic [6:0] CH_I = 7'h49;
    localparam logic [6:0] CH_NONE = 7'h00;

    // digit positions, most significant first
    localparam logic [1:0] POS_THOU = 2'd0;
    localparam logic [1:0] POS_HUND = 2'd1;
    localparam logic [1:0] POS_TENS = 2'd2;
    localparam logic [1:0] POS_UNIT = 2'd3;

    typedef struct packed {
        logic            err;
        logic [3:0][3:0] dig;   // [0] thousands .. [3] units
        logic [3:0][3:0] len;   // characters per digit
    } t_entry;

    // characters needed for one digit (thousands use the digit itself)
    function automatic logic [3:0] digit_len(input logic [1:0] pos, input logic [3:0] d);
        logic [3:0] n;
        if (pos == POS_THOU) begin
            n = d;
        end else if (d == 4'd9 || d == 4'd4) begin
            n = 4'd2;
        end else if (d >= 4'd5) begin
            n = d - 4'd4;
        end else begin
            n = d;
        end
        return n;
    endfunction

    // character k of the numeral of digit d at position pos
    function automatic logic [6:0] sym_of(input logic [1:0] pos, input logic [3:0] d,
                                          input logic [3:0] k);
        logic [6:0] c_one;
        logic [6:0] c_five;
        logic [6:0] c_ten;
        logic [6:0] c;
        case (pos)
            POS_HUND: begin
                c_one = CH_C; c_five = CH_D; c_ten = CH_M;
            end
            POS_TENS: begin
                c_one = CH_X; c_five = CH_L; c_ten = CH_C;
            end
            default: begin
                c_one = CH_I; c_five = CH_V; c_ten = CH_X;
            end
        endcase
        if (pos == POS_THOU) begin
            c = CH_M;
        end else if (d == 4'd9) begin
            c = (k == 4'd0) ? c_one : c_ten;
        end else if (d >= 4'd5) begin
            c = (k == 4'd0) ? c_five : c_one;
        end else if (d == 4'd4) begin
            c = (k == 4'd0) ? c_one : c_five;
        end else begin
            c = c_one;
        end
        return c;
    endfunction

endpackage

@@ sv/rne_front.sv @@
module rne_front
    import rne_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [13:0]  i_value,
    output logic         o_full,
    output logic         o_q_push,
    output t_entry       o_entry,
    input  logic         i_q_full
);

    // reciprocals: exact quotients over the whole valid range
    localparam logic [14:0] RECIP_1000 = 15'd16778;  // 2^24 / 1000, rounded up
    localparam logic [9:0]  RECIP_100  = 10'd656;    // 2^16 / 100, rounded up
    localparam logic [7:0]  RECIP_10   = 8'd205;     // 2^11 / 10, rounded up

    logic [6:0]  r_vld;
    logic        w_adv;

    logic [13:0] r1_v;
    logic [3:0]  r1_th;
    logic        r1_bad;
    logic [9:0]  r2_rem;
    logic [3:0]  r2_th;
    logic        r2_bad;
    logic [9:0]  r3_rem;
    logic [3:0]  r3_th, r3_h;
    logic        r3_bad;
    logic [6:0]  r4_rem;
    logic [3:0]  r4_th, r4_h;
    logic        r4_bad;
    logic [6:0]  r5_rem;
    logic [3:0]  r5_th, r5_h, r5_t;
    logic        r5_bad;
    logic [3:0]  r6_th, r6_h, r6_t, r6_u;
    logic        r6_bad;
    t_entry      r7_entry;

    logic [28:0] w_p1;
    logic [13:0] w_th_k, w_rem1;
    logic [19:0] w_p3;
    logic [9:0]  w_h_k, w_rem2;
    logic [14:0] w_p5;
    logic [6:0]  w_t_k, w_u;
    logic [3:0]  w_l0, w_l1, w_l2, w_l3;
    logic [5:0]  w_sum;

    // whole pipe moves together whenever its tail can drain
    assign w_adv    = !r_vld[6] || !i_q_full;
    assign o_full   = !w_adv;
    assign o_q_push = r_vld[6] && !i_q_full;
    assign o_entry  = r7_entry;

    assign w_p1   = 29'(i_value) * 29'(RECIP_1000);
    assign w_th_k = 14'(r1_th) * 14'd1000;
    assign w_rem1 = r1_v - w_th_k;
    assign w_p3   = 20'(r2_rem) * 20'(RECIP_100);
    assign w_h_k  = 10'(r3_h) * 10'd100;
    assign w_rem2 = r3_rem - w_h_k;
    assign w_p5   = 15'(r4_rem) * 15'(RECIP_10);
    assign w_t_k  = 7'(r5_t) * 7'd10;
    assign w_u    = r5_rem - w_t_k;

    assign w_l0  = digit_len(POS_THOU, r6_th);
    assign w_l1  = digit_len(POS_HUND, r6_h);
    assign w_l2  = digit_len(POS_TENS, r6_t);
    assign w_l3  = digit_len(POS_UNIT, r6_u);
    assign w_sum = 6'(w_l0) + 6'(w_l1) + 6'(w_l2) + 6'(w_l3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[5:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_v   <= i_value;
            r1_th  <= w_p1[27:24];
            r1_bad <= (i_value == 14'd0) || (i_value > VALUE_MAX);

            r2_rem <= w_rem1[9:0];
            r2_th  <= r1_th;
            r2_bad <= r1_bad;

            r3_rem <= r2_rem;
            r3_th  <= r2_th;
            r3_h   <= w_p3[19:16];
            r3_bad <= r2_bad;

            r4_rem <= w_rem2[6:0];
            r4_th  <= r3_th;
            r4_h   <= r3_h;
            r4_bad <= r3_bad;

            r5_rem <= r4_rem;
            r5_th  <= r4_th;
            r5_h   <= r4_h;
            r5_t   <= w_p5[14:11];
            r5_bad <= r4_bad;

            r6_th  <= r5_th;
            r6_h   <= r5_h;
            r6_t   <= r5_t;
            r6_u   <= w_u[3:0];
            r6_bad <= r5_bad;

            // out of range or too long for the result limit
            r7_entry.err    <= r6_bad || (w_sum > MAX_CHARS);
            r7_entry.dig[0] <= r6_th;
            r7_entry.dig[1] <= r6_h;
            r7_entry.dig[2] <= r6_t;
            r7_entry.dig[3] <= r6_u;
            r7_entry.len[0] <= w_l0;
            r7_entry.len[1] <= w_l1;
            r7_entry.len[2] <= w_l2;
            r7_entry.len[3] <= w_l3;
        end
    end

endmodule

@@ sv/rne_queue.sv @@
`include "roman_numeral_encoder_defines.svh"

module rne_queue
    import rne_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_entry  o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr, n_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `RNE_ASSERT(a_q_no_overflow, i_push, !o_full || i_pop, "queue written while full")
    `RNE_ASSERT(a_q_no_underflow, i_pop, o_valid, "queue read while empty")
    `RNE_ASSERT(a_q_count_max, 1'b1, r_count <= CW'(DEPTH), "queue count past depth")

endmodule

@@ sv/rne_back.sv @@
`include "roman_numeral_encoder_defines.svh"

module rne_back
    import rne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_entry      i_entry,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [6:0]  o_symbol,
    output logic        o_last,
    output logic        o_error
);

    logic            r_busy;
    logic            r_err;
    logic [3:0][3:0] r_dig;
    logic [3:0][3:0] r_len;
    logic [3:0][3:0] r_rem;

    logic            r_out_vld;
    logic [6:0]      r_out_sym;
    logic            r_out_last;
    logic            r_out_err;

    logic [1:0]      w_sel;
    logic            w_found;
    logic            w_rest_zero;
    logic [3:0]      w_k;
    logic            w_is_last;
    logic [6:0]      w_sym;
    logic            w_out_ready;
    logic            w_step;
    logic            w_load;

    // oldest digit that still owes characters
    always_comb begin
        w_sel   = POS_THOU;
        w_found = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (!w_found && r_rem[i] != 4'd0) begin
                w_sel   = 2'(i);
                w_found = 1'b1;
            end
        end
    end

    always_comb begin
        w_rest_zero = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (2'(i) > w_sel && r_rem[i] != 4'd0) begin
                w_rest_zero = 1'b0;
            end
        end
    end

    assign w_k         = r_len[w_sel] - r_rem[w_sel];
    assign w_is_last   = r_err || ((r_rem[w_sel] == 4'd1) && w_rest_zero);
    assign w_sym       = r_err ? CH_NONE : sym_of(w_sel, r_dig[w_sel], w_k);
    assign w_out_ready = !r_out_vld || i_pop;
    assign w_step      = r_busy && w_out_ready;
    assign w_load      = i_q_valid && (!r_busy || (w_step && w_is_last));

    assign o_q_pop  = w_load;
    assign o_empty  = !r_out_vld;
    assign o_symbol = r_out_sym;
    assign o_last   = r_out_last;
    assign o_error  = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
            r_rem     <= '0;
        end else begin
            if (w_step) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            // a new number loads when idle, or replaces the one whose last character just left
            if (w_load) begin
                r_busy <= 1'b1;
                r_rem  <= i_entry.err ? '0 : i_entry.len;
            end else if (w_step) begin
                if (!r_err) begin
                    r_rem[w_sel] <= r_rem[w_sel] - 4'd1;
                end
                if (w_is_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_sym  <= w_sym;
            r_out_last <= w_is_last;
            r_out_err  <= r_err;
        end
        if (w_load) begin
            r_err <= i_entry.err;
            r_dig <= i_entry.dig;
            r_len <= i_entry.len;
        end
    end

    `RNE_ASSERT(a_err_is_last, r_out_vld && r_out_err, r_out_last, "error beat not last")
    `RNE_ASSERT(a_err_no_sym, r_out_vld && r_out_err, r_out_sym == CH_NONE, "error beat has symbol")
    `RNE_ASSERT(a_ok_has_sym, r_out_vld && !r_out_err, r_out_sym != CH_NONE, "numeral beat empty")
    `RNE_ASSERT_NEXT(a_busy_holds, w_step && !w_is_last, r_busy, "numeral cut short")

endmodule

@@ sv/roman_numeral_encoder.sv @@
// Roman numeral encoder. Each number pushed in (1 to 9999) comes out as its
// Roman numeral, one ASCII character per result beat, oldest first, with last
// set on the final character. Thousands are written as repeated M; hundreds,
// tens and units use the subtractive forms. Zero, values above 9999, and
// numerals longer than fifteen characters give one beat with symbol 0, last
// and error set. A number first passes a seven-stage front pipeline (digit
// split by reciprocal multiplies, then character counts and range checks),
// waits in a small queue, and is then spelled out by the back sequencer.
// The back sequencer sends one character per cycle while the result side
// is popped, so a number whose numeral has n characters takes n result
// beats (one beat for an error), at most fifteen. The queue lets new
// numbers enter while earlier ones are still being spelled out; push sees
// full only when the queue is full and the last front stage holds a
// number.
module roman_numeral_encoder
    import rne_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4    // numbers held between front and back
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side
    input  logic        push,
    output logic        full,
    input  logic [13:0] i_value,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  o_symbol,
    output logic        o_last,
    output logic        o_error
);

    // front to queue
    logic   w_f_push;
    t_entry w_f_entry;
    logic   w_q_full;

    // queue to back
    logic   w_q_valid;
    t_entry w_q_entry;
    logic   w_q_pop;

    // digit split, character counts and error classification
    rne_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_value  (i_value),
        .o_full   (full),
        .o_q_push (w_f_push),
        .o_entry  (w_f_entry),
        .i_q_full (w_q_full)
    );

    // decouples classification from spelling
    rne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_entry (w_f_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    // spells one character per beat into the output register
    rne_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_entry   (w_q_entry),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_symbol  (o_symbol),
        .o_last    (o_last),
        .o_error   (o_error)
    );

endmodule
